// ===== rtl/vlch_pkg.sv =====
// ----------------------------------------------------------------------------
// vlch_pkg
// Shared constants and types of the voxel label corner homogeneity core.
// ----------------------------------------------------------------------------
package vlch_pkg;

    // default image limits and label width
    localparam int DEF_MAX_X      = 64;
    localparam int DEF_MAX_Y      = 64;
    localparam int DEF_MAX_Z      = 1024;
    localparam int DEF_LABEL_BITS = 16;

    // configuration port and register widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int XREG_W     = 7;
    localparam int YREG_W     = 7;
    localparam int ZREG_W     = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SIZE = 2'd2;

    // register reset values
    localparam logic [XREG_W-1:0] XREG_RESET = 7'd64;
    localparam logic [YREG_W-1:0] YREG_RESET = 7'd64;
    localparam logic [ZREG_W-1:0] ZREG_RESET = 11'd64;

    // position flags of the voxel being taken
    typedef struct packed {
        logic interior;
        logic last;
    } t_pos_flags;

endpackage

// ===== rtl/voxel_label_corner_homogeneity_core.sv =====
// ----------------------------------------------------------------------------
// voxel_label_corner_homogeneity_core
// Flags interior voxels of a raster-order 3D label image whose eight corner
// neighbours all carry the centre label.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------
//  voxel    | in        | i_valid / o_stall     | i_label
//  result   | out       | o_valid / i_stall     | o_white, o_last
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one voxel per clock unless o_stall is high; a result leaves after its far corner
//  voxel is taken, passing the row memory read, the plane memory read and the output
//  register. reset is synchronous and needs no clearing pass: the delay memories
//  are only read at entries written earlier in the same frame. the whole pipe
//  holds while a result sits in the output register and i_stall is high.
// ----------------------------------------------------------------------------
module voxel_label_corner_homogeneity_core #(
    parameter int MAX_X      = vlch_pkg::DEF_MAX_X,
    parameter int MAX_Y      = vlch_pkg::DEF_MAX_Y,
    parameter int MAX_Z      = vlch_pkg::DEF_MAX_Z,
    parameter int LABEL_BITS = vlch_pkg::DEF_LABEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [LABEL_BITS-1:0]           i_label,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_white,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vlch_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vlch_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vlch_pkg::*;

    localparam int LBW = LABEL_BITS;
    localparam int XSW = $clog2(MAX_X + 1);
    localparam int YSW = $clog2(MAX_Y + 1);
    localparam int PLW = XSW + YSW;
    localparam int RD  = 2 * MAX_X;
    localparam int RAW = $clog2(RD);
    localparam int PD  = 2 * MAX_X * MAX_Y;
    localparam int PAW = $clog2(PD);

    // circular step back in the row memory
    function automatic logic [RAW-1:0] row_back(logic [RAW-1:0] wp, logic [RAW:0] lag);
        logic [RAW:0] w;
        logic [RAW:0] r;
        w = {1'b0, wp};
        if (w >= lag) begin
            r = w - lag;
        end else begin
            r = w + (RAW+1)'(RD) - lag;
        end
        return r[RAW-1:0];
    endfunction

    // circular step back in the plane memory
    function automatic logic [PAW-1:0] pl_back(logic [PAW-1:0] wp, logic [PAW:0] lag);
        logic [PAW:0] w;
        logic [PAW:0] r;
        w = {1'b0, wp};
        if (w >= lag) begin
            r = w - lag;
        end else begin
            r = w + (PAW+1)'(PD) - lag;
        end
        return r[PAW-1:0];
    endfunction

    logic           adv;
    logic           in_acc;
    logic           r_out_valid;
    logic [XSW-1:0] xs;
    logic [PLW-1:0] plane;
    t_pos_flags     flags;

    // pipe advances unless a result is held back
    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;
    assign in_acc  = i_valid && adv;

    vlch_frame_ctrl #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_frame_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (in_acc),
        .o_xs        (xs),
        .o_plane     (plane),
        .o_flags     (flags)
    );

    // ---------------- stage 0: row pairs and row memory ----------------
    logic [LBW-1:0] r_l1;
    logic [LBW-1:0] r_l2;
    logic           eqx;
    logic [RAW-1:0] r_row_wp;
    logic [RAW-1:0] row_rd_addr;
    logic [LBW:0]   r_row_mem [0:RD-1];
    logic [LBW:0]   r_row_rd;

    // last two labels of the stream, same row whenever x is two or more
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_l1 <= i_label;
            r_l2 <= r_l1;
        end
    end

    assign eqx         = (i_label == r_l2);
    assign row_rd_addr = row_back(r_row_wp, (RAW+1)'(xs) << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_wp <= '0;
        end else if (in_acc) begin
            r_row_wp <= (r_row_wp == RAW'(RD - 1)) ? '0 : r_row_wp + RAW'(1);
        end
    end

    // row memory: label and x pair match, read two rows back
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row_mem[r_row_wp] <= {eqx, i_label};
        end
        if (adv) begin
            r_row_rd <= r_row_mem[row_rd_addr];
        end
    end

    logic           r_s1_valid;
    logic [LBW-1:0] r_s1_label;
    logic           r_s1_eqx;
    t_pos_flags     r_s1_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_label <= i_label;
            r_s1_eqx   <= eqx;
            r_s1_flags <= flags;
        end
    end

    // ---------------- stage 1: plane memory ----------------
    logic           q;
    logic [PAW-1:0] r_pl_wp;
    logic [PAW-1:0] pl_far_addr;
    logic [PAW-1:0] pl_ctr_addr;
    logic [LBW:0]   r_pl_mem [0:PD-1];
    logic [LBW:0]   r_pl_far;
    logic [LBW-1:0] r_pl_ctr;

    // four corners of one plane agree
    assign q = r_s1_eqx && r_row_rd[LBW] && (r_s1_label == r_row_rd[LBW-1:0]);

    assign pl_far_addr = pl_back(r_pl_wp, (PAW+1)'(plane) << 1);
    assign pl_ctr_addr = pl_back(r_pl_wp, (PAW+1)'(plane) + (PAW+1)'(xs) + (PAW+1)'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pl_wp <= '0;
        end else if (adv && r_s1_valid) begin
            r_pl_wp <= (r_pl_wp == PAW'(PD - 1)) ? '0 : r_pl_wp + PAW'(1);
        end
    end

    // plane memory: label and plane corner match, read at z-2 and at the centre
    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_pl_mem[r_pl_wp] <= {q, r_s1_label};
        end
        if (adv) begin
            r_pl_far <= r_pl_mem[pl_far_addr];
            r_pl_ctr <= r_pl_mem[pl_ctr_addr][LBW-1:0];
        end
    end

    logic           r_s2_valid;
    logic [LBW-1:0] r_s2_label;
    logic           r_s2_q;
    t_pos_flags     r_s2_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_label <= r_s1_label;
            r_s2_q     <= q;
            r_s2_flags <= r_s1_flags;
        end
    end

    // ---------------- stage 2: corner decision and output register ----------------
    logic white;
    logic r_out_white;
    logic r_out_last;

    assign white = r_s2_q && r_pl_far[LBW] && (r_s2_label == r_pl_far[LBW-1:0])
                   && (r_s2_label == r_pl_ctr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid && r_s2_flags.interior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_white <= white;
            r_out_last  <= r_s2_flags.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_white = r_out_white;
    assign o_last  = r_out_last;

endmodule

// ===== rtl/vlch_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// vlch_frame_ctrl
// Size registers, clamping, plane size and the x/y/z raster position counters.
// ----------------------------------------------------------------------------
module vlch_frame_ctrl #(
    parameter int MAX_X = vlch_pkg::DEF_MAX_X,
    parameter int MAX_Y = vlch_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vlch_pkg::DEF_MAX_Z,
    localparam int XSW = $clog2(MAX_X + 1),
    localparam int YSW = $clog2(MAX_Y + 1),
    localparam int PLW = XSW + YSW
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vlch_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vlch_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_step,
    output logic [XSW-1:0]                     o_xs,
    output logic [PLW-1:0]                     o_plane,
    output vlch_pkg::t_pos_flags               o_flags
);
    import vlch_pkg::*;

    localparam int ZSW = $clog2(MAX_Z + 1);
    localparam int XPW = $clog2(MAX_X);
    localparam int YPW = $clog2(MAX_Y);
    localparam int ZPW = $clog2(MAX_Z);

    logic [XREG_W-1:0] r_x_size;
    logic [YREG_W-1:0] r_y_size;
    logic [ZREG_W-1:0] r_z_size;
    logic [XPW-1:0]    r_x;
    logic [YPW-1:0]    r_y;
    logic [ZPW-1:0]    r_z;
    logic [PLW-1:0]    r_plane;
    logic [XSW-1:0]    xs;
    logic [YSW-1:0]    ys;
    logic [ZSW-1:0]    zs;
    logic              cfg_hit;
    logic              x_wrap;
    logic              y_wrap;
    logic              z_wrap;

    assign o_cfg_ready = 1'b1;

    // clamp register values to [3, max]
    always_comb begin
        if (r_x_size < XREG_W'(3)) begin
            xs = XSW'(3);
        end else if (32'(r_x_size) > MAX_X) begin
            xs = XSW'(MAX_X);
        end else begin
            xs = XSW'(r_x_size);
        end
        if (r_y_size < YREG_W'(3)) begin
            ys = YSW'(3);
        end else if (32'(r_y_size) > MAX_Y) begin
            ys = YSW'(MAX_Y);
        end else begin
            ys = YSW'(r_y_size);
        end
        if (r_z_size < ZREG_W'(3)) begin
            zs = ZSW'(3);
        end else if (32'(r_z_size) > MAX_Z) begin
            zs = ZSW'(MAX_Z);
        end else begin
            zs = ZSW'(r_z_size);
        end
    end

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= XREG_RESET;
            r_y_size <= YREG_RESET;
            r_z_size <= ZREG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_SIZE: r_x_size <= i_cfg_data[XREG_W-1:0];
                CFG_Y_SIZE: r_y_size <= i_cfg_data[YREG_W-1:0];
                CFG_Z_SIZE: r_z_size <= i_cfg_data[ZREG_W-1:0];
                default:    r_x_size <= r_x_size;
            endcase
        end
    end

    always_comb begin
        unique case (i_cfg_index)
            CFG_X_SIZE, CFG_Y_SIZE, CFG_Z_SIZE: cfg_hit = i_cfg_valid;
            default:                            cfg_hit = 1'b0;
        endcase
    end

    // plane size, registered from the clamped x and y sizes
    always_ff @(posedge i_clk) begin
        r_plane <= PLW'(xs) * PLW'(ys);
    end

    assign x_wrap = (XSW'(r_x) + XSW'(1)) >= xs;
    assign y_wrap = (YSW'(r_y) + YSW'(1)) >= ys;
    assign z_wrap = (ZSW'(r_z) + ZSW'(1)) >= zs;

    // raster position counters, restarted by a write to a size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else if (cfg_hit) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else if (i_step) begin
            if (x_wrap) begin
                r_x <= '0;
                if (y_wrap) begin
                    r_y <= '0;
                    r_z <= z_wrap ? '0 : r_z + ZPW'(1);
                end else begin
                    r_y <= r_y + YPW'(1);
                end
            end else begin
                r_x <= r_x + XPW'(1);
            end
        end
    end

    // flags for the voxel at the current position
    assign o_flags.interior = (r_x >= XPW'(2)) && (r_y >= YPW'(2)) && (r_z >= ZPW'(2));
    assign o_flags.last     = (XSW'(r_x) == xs - XSW'(1)) && (YSW'(r_y) == ys - YSW'(1))
                              && (ZSW'(r_z) == zs - ZSW'(1));
    assign o_xs    = xs;
    assign o_plane = r_plane;

endmodule

// ===== tb/voxel_label_corner_homogeneity_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_label_corner_homogeneity_core_test
// Streams raster-order label volumes of several geometries through the core
// and checks every corner-homogeneity flag against a local predictor of the
// delay store, the raster position and the size registers. Covers reset
// geometry, clamped sizes, frame wrap, restarts on register writes, random
// idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module voxel_label_corner_homogeneity_core_test;
    import vlch_pkg::*;

    localparam int LABEL_W       = DEF_LABEL_BITS;
    localparam int STORE_DEPTH   = 2 * DEF_MAX_X * DEF_MAX_Y + 2 * DEF_MAX_X + 3;
    localparam int RESET_CYCLES  = 8;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_PCT      = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_VOXELS = 60;
    localparam int LIMIT_NS      = 250_000;

    // register index that decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // voxel positions inside a 3x3x3 frame
    localparam int CENTRE_IDX = 13;
    localparam int FACE_IDX   = 4;
    localparam int EDGE_IDX   = 1;

    typedef struct packed {
        logic white;
        logic last;
    } t_corner_flags;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [LABEL_W-1:0]    i_label     = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic                  o_white;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor state
    logic [LABEL_W-1:0] label_hist [STORE_DEPTH];
    int unsigned        hist_wr;
    logic [XREG_W-1:0]  x_reg;
    logic [YREG_W-1:0]  y_reg;
    logic [ZREG_W-1:0]  z_reg;
    int unsigned        x_pos, y_pos, z_pos;
    t_corner_flags      pending_flags [$];

    t_corner_flags want_flags;
    int unsigned   errors = 0;
    bit            quiet = 1'b0;
    int unsigned   hold_asked = 0;
    int unsigned   hold_done = 0;
    int unsigned   hold_left = 0;

    voxel_label_corner_homogeneity_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_label     (i_label),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_white     (o_white),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned frame_voxels();
        return fit_size(x_reg, DEF_MAX_X) * fit_size(y_reg, DEF_MAX_Y) *
               fit_size(z_reg, DEF_MAX_Z);
    endfunction

    // label taken lag transfers before the newest one
    function automatic logic [LABEL_W-1:0] label_back(input int unsigned lag);
        int unsigned newest;
        newest = (hist_wr + STORE_DEPTH - 1) % STORE_DEPTH;
        return label_hist[(newest + STORE_DEPTH - lag) % STORE_DEPTH];
    endfunction

    task automatic reset_corner_model();
        x_reg   = XREG_RESET;
        y_reg   = YREG_RESET;
        z_reg   = ZREG_RESET;
        hist_wr = 0;
        x_pos   = 0;
        y_pos   = 0;
        z_pos   = 0;
        pending_flags.delete();
    endtask

    task automatic apply_size_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        bit restart;
        restart = 1'b1;
        case (idx)
            CFG_X_SIZE: x_reg = val[XREG_W-1:0];
            CFG_Y_SIZE: y_reg = val[YREG_W-1:0];
            CFG_Z_SIZE: z_reg = val[ZREG_W-1:0];
            default: restart = 1'b0;
        endcase
        if (restart) begin
            x_pos = 0;
            y_pos = 0;
            z_pos = 0;
        end
    endtask

    task automatic predict_corner_flags(input logic [LABEL_W-1:0] lbl);
        int unsigned        xs, ys, zs, plane;
        logic [LABEL_W-1:0] centre;
        t_corner_flags      flags;
        xs    = fit_size(x_reg, DEF_MAX_X);
        ys    = fit_size(y_reg, DEF_MAX_Y);
        zs    = fit_size(z_reg, DEF_MAX_Z);
        plane = xs * ys;
        label_hist[hist_wr] = lbl;
        hist_wr = (hist_wr + 1) % STORE_DEPTH;

        // far corner of an interior voxel just arrived
        if (x_pos >= 2 && y_pos >= 2 && z_pos >= 2) begin
            centre      = label_back(plane + xs + 1);
            flags.white = 1'b1;
            for (int dz = 0; dz <= 2; dz += 2)
                for (int dy = 0; dy <= 2; dy += 2)
                    for (int dx = 0; dx <= 2; dx += 2)
                        if (label_back(dz * plane + dy * xs + dx) != centre)
                            flags.white = 1'b0;
            flags.last = (x_pos == xs - 1 && y_pos == ys - 1 && z_pos == zs - 1);
            pending_flags.push_back(flags);
        end

        // raster advance with frame wrap
        if (x_pos + 1 >= xs) begin
            x_pos = 0;
            if (y_pos + 1 >= ys) begin
                y_pos = 0;
                z_pos = (z_pos + 1 >= zs) ? 0 : z_pos + 1;
            end else begin
                y_pos++;
            end
        end else begin
            x_pos++;
        end
    endtask

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------
    task automatic send_voxel(input logic [LABEL_W-1:0] lbl);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_label <= lbl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_corner_flags(lbl);
    endtask

    // mostly base label, noise_pct percent replaced by a near or random label
    task automatic send_run(input logic [LABEL_W-1:0] base, input int unsigned noise_pct,
                            input int unsigned n);
        logic [LABEL_W-1:0] lbl;
        for (int unsigned k = 0; k < n; k++) begin
            lbl = base;
            if ($urandom_range(99) < noise_pct) begin
                if ($urandom_range(1))
                    lbl = base ^ (LABEL_W'(1) << $urandom_range(LABEL_W - 1));
                else
                    lbl = LABEL_W'($urandom());
            end
            send_voxel(lbl);
        end
    endtask

    // one frame of base label with a single odd voxel
    task automatic send_frame_odd(input logic [LABEL_W-1:0] base, input int unsigned odd_idx,
                                  input logic [LABEL_W-1:0] odd_lbl);
        int unsigned n;
        n = frame_voxels();
        for (int unsigned k = 0; k < n; k++)
            send_voxel((k == odd_idx) ? odd_lbl : base);
    endtask

    // register write; valid drops afterwards unless another write follows
    task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val, input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_size_write(idx, val);
        if (!more)
            i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] xv,
                                input logic [CFG_DATA_W-1:0] yv,
                                input logic [CFG_DATA_W-1:0] zv);
        write_size_reg(CFG_X_SIZE, xv, 1'b1);
        write_size_reg(CFG_Y_SIZE, yv, 1'b1);
        write_size_reg(CFG_Z_SIZE, zv, 1'b0);
    endtask

    // stop sending, let every expected result arrive, then let the pipe settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_flags.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall, plus long hold-offs on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_asked) begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_flags.size() == 0) begin
                $display("%0t: result with none expected, white %b last %b",
                         $time, o_white, o_last);
                errors++;
            end else begin
                want_flags = pending_flags.pop_front();
                if (o_white !== want_flags.white) begin
                    $display("%0t: white expected %b actual %b",
                             $time, want_flags.white, o_white);
                    errors++;
                end
                if (o_last !== want_flags.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, want_flags.last, o_last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // 64x64x64 from reset: one row, far too early for any result
    task automatic test_reset_geometry();
        send_run(LABEL_W'($urandom()), 1, 64);
        wait_idle();
    endtask

    // 3x3x3 frames: uniform, each corner odd, centre odd, non-corner odd
    task automatic test_corner_mismatch();
        logic [LABEL_W-1:0] base;
        set_geometry(11'h780, 11'h002, 11'd3);
        send_frame_odd({LABEL_W{1'b1}}, CENTRE_IDX, {LABEL_W{1'b1}});
        for (int dz = 0; dz <= 2; dz += 2)
            for (int dy = 0; dy <= 2; dy += 2)
                for (int dx = 0; dx <= 2; dx += 2) begin
                    base = LABEL_W'($urandom());
                    send_frame_odd(base, dx + 3 * dy + 9 * dz,
                                   base ^ (LABEL_W'(1) << $urandom_range(LABEL_W - 1)));
                end
        base = LABEL_W'($urandom());
        send_frame_odd(base, CENTRE_IDX, ~base);
        send_frame_odd(base, FACE_IDX, ~base);
        send_frame_odd(base, EDGE_IDX, ~base);
        wait_idle();
    endtask

    // register values outside the legal range
    task automatic test_size_clamp();
        set_geometry(11'h7C3, 11'd2, 11'd3);
        send_run(LABEL_W'($urandom()), 5, frame_voxels());
        wait_idle();
    endtask

    // valid index restarts the frame, unknown index does not
    task automatic test_frame_restart();
        set_geometry(11'd4, 11'd3, 11'd3);
        send_run(16'h5A5A, 4, 20);
        wait_idle();
        write_size_reg(CFG_UNUSED, 11'h7FF, 1'b0);
        send_run(16'h5A5A, 4, 16 + 36);
        wait_idle();
        send_run(16'hA5A5, 4, 20);
        wait_idle();
        write_size_reg(CFG_X_SIZE, 11'd4, 1'b0);
        send_run(16'hA5A5, 4, 36);
        wait_idle();
    endtask

    // deep frame: 3x3 planes from a z register above the limit, first seven planes
    task automatic test_long_z_frame();
        set_geometry(11'd0, 11'd1, 11'h7FF);
        send_run(LABEL_W'($urandom()), 2, 63);
        wait_idle();
    endtask

    // long output hold-off while voxels keep coming
    task automatic test_backpressure();
        set_geometry(11'd5, 11'd4, 11'd5);
        hold_asked++;
        send_run(LABEL_W'($urandom()), 8, 120);
        wait_idle();
    endtask

    // full rate on both channels
    task automatic test_no_idle_stretch();
        set_geometry(11'd6, 11'd5, 11'd4);
        quiet = 1'b1;
        send_run(LABEL_W'($urandom()), 6, 120);
        wait_idle();
        quiet = 1'b0;
    endtask

    // random small geometries, whole frames mostly, some cut short
    task automatic test_random_frames();
        logic [CFG_IDX_W-1:0]  wr_idx [4];
        logic [CFG_DATA_W-1:0] wr_val [4];
        int unsigned           n_wr, sent, n, noise;
        sent = 0;
        while (sent < RANDOM_VOXELS) begin
            n_wr = 0;
            if ($urandom_range(9) == 0) begin
                wr_idx[n_wr] = CFG_UNUSED;
                wr_val[n_wr] = CFG_DATA_W'($urandom());
                n_wr++;
            end
            if ($urandom_range(3) != 0) begin
                wr_idx[n_wr] = CFG_X_SIZE;
                wr_val[n_wr] = {4'($urandom()), 7'($urandom_range(5))};
                n_wr++;
            end
            if ($urandom_range(3) != 0) begin
                wr_idx[n_wr] = CFG_Y_SIZE;
                wr_val[n_wr] = {4'($urandom()), 7'($urandom_range(5))};
                n_wr++;
            end
            if ($urandom_range(3) != 0) begin
                wr_idx[n_wr] = CFG_Z_SIZE;
                wr_val[n_wr] = CFG_DATA_W'($urandom_range(4));
                n_wr++;
            end
            for (int k = 0; k < n_wr; k++)
                write_size_reg(wr_idx[k], wr_val[k], k != n_wr - 1);

            case ($urandom_range(3))
                0: noise = 0;
                1: noise = 2;
                2: noise = 6;
                default: noise = 25;
            endcase
            n = frame_voxels() * $urandom_range(1, 2);
            if ($urandom_range(7) == 0)
                n = $urandom_range(1, n - 1);
            send_run(LABEL_W'($urandom()), noise, n);
            sent += n;
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_corner_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_geometry();
        test_corner_mismatch();
        test_size_clamp();
        test_frame_restart();
        test_long_z_frame();
        test_backpressure();
        test_no_idle_stretch();
        test_random_frames();
        wait_idle();
        if (errors == 0)
            $display("voxel_label_corner_homogeneity_core_test: PASS");
        else
            $display("voxel_label_corner_homogeneity_core_test: FAIL");
        $finish;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("%0t: timeout", $time);
        $display("voxel_label_corner_homogeneity_core_test: FAIL");
        $finish;
    end

endmodule
